// ===== rtl/tcr_pkg.sv =====
package tcr_pkg;

   localparam int COORD_WIDTH  = 32;
   localparam int RADIUS_WIDTH = 48;

   localparam logic [RADIUS_WIDTH-1:0] RADIUS_MAX = '1;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] first_x;
      logic signed [COORD_WIDTH-1:0] first_y;
      logic signed [COORD_WIDTH-1:0] first_z;
      logic signed [COORD_WIDTH-1:0] second_x;
      logic signed [COORD_WIDTH-1:0] second_y;
      logic signed [COORD_WIDTH-1:0] second_z;
      logic signed [COORD_WIDTH-1:0] third_x;
      logic signed [COORD_WIDTH-1:0] third_y;
      logic signed [COORD_WIDTH-1:0] third_z;
   } req_type;

   typedef struct packed {
      logic [RADIUS_WIDTH-1:0] circle_radius;
      logic                    degenerate;
   } rsp_type;

endpackage

// ===== rtl/tcr_isqrt.sv =====
module tcr_isqrt #(
   parameter int LANE_COUNT = 1,
   parameter int RAD_WIDTH  = 66
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  logic                     in_valid,
   input  logic [RAD_WIDTH-1:0]     radicand [LANE_COUNT],
   output logic                     out_valid,
   output logic [RAD_WIDTH/2-1:0]   root [LANE_COUNT]
);

   localparam int RootWidth = RAD_WIDTH / 2;
   localparam int RemWidth  = RootWidth + 2;

   logic [RootWidth-1:0] valid_ff;
   logic [RemWidth-1:0]  rem_ff  [RootWidth][LANE_COUNT];
   logic [RootWidth-1:0] root_ff [RootWidth][LANE_COUNT];
   logic [RAD_WIDTH-1:0] rad_ff  [RootWidth][LANE_COUNT];

   for (genvar k = 0; k < RootWidth; k++) begin : g_stage
      logic                 src_valid;
      logic [RemWidth-1:0]  src_rem  [LANE_COUNT];
      logic [RootWidth-1:0] src_root [LANE_COUNT];
      logic [RAD_WIDTH-1:0] src_rad  [LANE_COUNT];
      logic [RemWidth-1:0]  rem_in   [LANE_COUNT];
      logic [RootWidth-1:0] root_in  [LANE_COUNT];
      logic [RAD_WIDTH-1:0] rad_in   [LANE_COUNT];

      if (k == 0) begin : g_first
         assign src_valid = in_valid;
         for (genvar l = 0; l < LANE_COUNT; l++) begin : g_lane
            assign src_rem[l]  = '0;
            assign src_root[l] = '0;
            assign src_rad[l]  = radicand[l];
         end
      end else begin : g_next
         assign src_valid = valid_ff[k-1];
         for (genvar l = 0; l < LANE_COUNT; l++) begin : g_lane
            assign src_rem[l]  = rem_ff[k-1][l];
            assign src_root[l] = root_ff[k-1][l];
            assign src_rad[l]  = rad_ff[k-1][l];
         end
      end

      always_comb begin
         logic [RemWidth-1:0] shifted;
         logic [RemWidth-1:0] trial;
         for (int l = 0; l < LANE_COUNT; l++) begin
            shifted = {src_rem[l][RemWidth-3:0], src_rad[l][RAD_WIDTH-1 -: 2]};
            trial   = {src_root[l], 2'b01};
            if (shifted >= trial) begin
               rem_in[l]  = shifted - trial;
               root_in[l] = {src_root[l][RootWidth-2:0], 1'b1};
            end else begin
               rem_in[l]  = shifted;
               root_in[l] = {src_root[l][RootWidth-2:0], 1'b0};
            end
            rad_in[l] = {src_rad[l][RAD_WIDTH-3:0], 2'b00};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (enable) begin
            valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= rad_in;
         end
      end
   end

   assign out_valid = valid_ff[RootWidth-1];
   assign root      = root_ff[RootWidth-1];

endmodule

// ===== rtl/triangle_circumradius_core.sv =====
// Channel   Ports                            Moves
// req       req_valid, req_ready, req_data   three points, signed Q16.16
// rsp       rsp_valid, rsp_ready, rsp_data   circumradius Q32.16 and degenerate flag
//
// One transaction enters per cycle while the rsp channel is not stalled.
// The side-length square root (33 stages), the Heron square root (69 stages)
// and the restoring divider (48 stages) each produce one bit per stage.
// Reset is synchronous and clears only valid bits. A stalled rsp channel freezes
// the whole pipeline; a one-entry input buffer takes one more transaction then.
module triangle_circumradius_core #(
   parameter int POINT_DIMENSION = 3
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tcr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tcr_pkg::rsp_type rsp_data
);

   localparam int CW        = tcr_pkg::COORD_WIDTH;
   localparam int RW        = tcr_pkg::RADIUS_WIDTH;
   localparam int SumWidth  = 2 * CW + 2;
   localparam int SideWidth = SumWidth / 2;
   localparam int ProdWidth = 138;
   localparam int DivWidth  = ProdWidth / 2;
   localparam int AbcWidth  = 3 * SideWidth;

   logic            enable;
   logic            accept;
   logic            entry_valid;
   tcr_pkg::req_type entry_data;
   logic            skid_valid_ff;
   tcr_pkg::req_type skid_data_ff;

   assign enable      = rsp_ready || !rsp_valid;
   assign req_ready   = !skid_valid_ff;
   assign accept      = req_valid && req_ready;
   assign entry_valid = skid_valid_ff || accept;
   assign entry_data  = skid_valid_ff ? skid_data_ff : req_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else if (enable) begin
         skid_valid_ff <= 1'b0;
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!enable && accept) begin
         skid_data_ff <= req_data;
      end
   end

   // Coordinate differences, magnitudes, squares and sums of squares.
   logic [CW-1:0] pt [3][3];
   assign pt[0][0] = entry_data.first_x;
   assign pt[0][1] = entry_data.first_y;
   assign pt[0][2] = entry_data.first_z;
   assign pt[1][0] = entry_data.second_x;
   assign pt[1][1] = entry_data.second_y;
   assign pt[1][2] = entry_data.second_z;
   assign pt[2][0] = entry_data.third_x;
   assign pt[2][1] = entry_data.third_y;
   assign pt[2][2] = entry_data.third_z;

   logic [2:0]    valid_ff;
   logic [CW:0]   mag_in [3][3];
   logic [CW:0]   mag_ff [3][3];
   logic [SumWidth-1:0] sq_ff [3][3];
   logic [SumWidth-1:0] sum_ff [3];

   always_comb begin
      logic [CW:0] diff;
      int          q;
      for (int s = 0; s < 3; s++) begin
         q = (s == 2) ? 0 : s + 1;
         for (int d = 0; d < 3; d++) begin
            diff = {pt[q][d][CW-1], pt[q][d]} - {pt[s][d][CW-1], pt[s][d]};
            if (d < POINT_DIMENSION) begin
               mag_in[s][d] = diff[CW] ? -diff : diff;
            end else begin
               mag_in[s][d] = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[1:0], entry_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         mag_ff <= mag_in;
         for (int s = 0; s < 3; s++) begin
            for (int d = 0; d < 3; d++) begin
               sq_ff[s][d] <= mag_ff[s][d] * mag_ff[s][d];
            end
            sum_ff[s] <= sq_ff[s][0] + sq_ff[s][1] + sq_ff[s][2];
         end
      end
   end

   // Side lengths.
   logic                 side_valid;
   logic [SideWidth-1:0] side [3];

   tcr_isqrt #(
      .LANE_COUNT (3),
      .RAD_WIDTH  (SumWidth)
   ) u_side_sqrt (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (valid_ff[2]),
      .radicand  (sum_ff),
      .out_valid (side_valid),
      .root      (side)
   );

   // Heron product and abc.
   logic [SideWidth+1:0] p_in;
   logic [SideWidth+1:0] q_in;
   logic [SideWidth+1:0] r_in;
   logic [SideWidth+1:0] s_in;
   logic                 deg_in;

   assign p_in = 35'(side[0]) + 35'(side[1]) + 35'(side[2]);
   assign q_in = 35'(side[1]) + 35'(side[2]) - 35'(side[0]);
   assign r_in = 35'(side[0]) + 35'(side[2]) - 35'(side[1]);
   assign s_in = 35'(side[0]) + 35'(side[1]) - 35'(side[2]);
   assign deg_in = q_in[34] || (q_in == '0) || r_in[34] || (r_in == '0)
                   || s_in[34] || (s_in == '0);

   logic [4:0]     hv_valid_ff;
   logic [4:0]     hv_deg_ff;
   logic [34:0]    p_ff;
   logic [33:0]    q_ff;
   logic [33:0]    r_ff;
   logic [33:0]    s_ff;
   logic [SideWidth-1:0] a_ff;
   logic [SideWidth-1:0] b_ff;
   logic [SideWidth-1:0] c_ff;
   logic [SideWidth-1:0] c1_ff;
   logic [68:0]    pq_ff;
   logic [67:0]    rs_ff;
   logic [65:0]    ab_ff;
   logic [68:0]    ll_ff;
   logic [68:0]    lh_ff;
   logic [67:0]    hl_ff;
   logic [67:0]    hh_ff;
   logic [65:0]    abl_ff;
   logic [65:0]    abh_ff;
   logic [102:0]   x_ff;
   logic [101:0]   y_ff;
   logic [AbcWidth-1:0] abc3_ff;
   logic [AbcWidth-1:0] abc4_ff;
   logic [ProdWidth-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hv_valid_ff <= '0;
      end else if (enable) begin
         hv_valid_ff <= {hv_valid_ff[3:0], side_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         hv_deg_ff <= {hv_deg_ff[3:0], deg_in};
         p_ff  <= p_in;
         q_ff  <= q_in[33:0];
         r_ff  <= r_in[33:0];
         s_ff  <= s_in[33:0];
         a_ff  <= side[0];
         b_ff  <= side[1];
         c_ff  <= side[2];
         pq_ff <= p_ff * q_ff;
         rs_ff <= r_ff * s_ff;
         ab_ff <= a_ff * b_ff;
         c1_ff <= c_ff;
         ll_ff <= pq_ff[34:0] * rs_ff[33:0];
         lh_ff <= pq_ff[34:0] * rs_ff[67:34];
         hl_ff <= pq_ff[68:35] * rs_ff[33:0];
         hh_ff <= pq_ff[68:35] * rs_ff[67:34];
         abl_ff <= ab_ff[32:0] * c1_ff;
         abh_ff <= ab_ff[65:33] * c1_ff;
         x_ff    <= 103'(ll_ff) + {lh_ff, 34'b0};
         y_ff    <= 102'(hl_ff) + {hh_ff, 34'b0};
         abc3_ff <= 99'(abl_ff) + {abh_ff, 33'b0};
         prod_ff <= 138'(x_ff) + 138'({y_ff, 35'b0});
         abc4_ff <= abc3_ff;
      end
   end

   // Root of the Heron product, with abc and the flag riding alongside.
   logic                 heron_valid;
   logic [ProdWidth-1:0] heron_rad [1];
   logic [DivWidth-1:0]  heron_root [1];
   logic [AbcWidth-1:0]  dly_abc_ff [DivWidth];
   logic [DivWidth-1:0]  dly_deg_ff;

   assign heron_rad[0] = prod_ff;

   tcr_isqrt #(
      .LANE_COUNT (1),
      .RAD_WIDTH  (ProdWidth)
   ) u_heron_sqrt (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (hv_valid_ff[4]),
      .radicand  (heron_rad),
      .out_valid (heron_valid),
      .root      (heron_root)
   );

   always_ff @(posedge clock) begin
      if (enable) begin
         dly_abc_ff[0] <= abc4_ff;
         dly_deg_ff    <= {dly_deg_ff[DivWidth-2:0], hv_deg_ff[4]};
         for (int k = 1; k < DivWidth; k++) begin
            dly_abc_ff[k] <= dly_abc_ff[k-1];
         end
      end
   end

   // Overflow check and division setup.
   logic                 ov_valid_ff;
   logic                 ov_sat_ff;
   logic                 ov_deg_ff;
   logic [DivWidth-1:0]  ov_rem_ff;
   logic [RW-1:0]        ov_low_ff;
   logic [DivWidth-1:0]  ov_div_ff;
   logic [AbcWidth-1:0]  abc_out;
   logic                 deg_out;

   assign abc_out = dly_abc_ff[DivWidth-1];
   assign deg_out = dly_deg_ff[DivWidth-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_valid_ff <= 1'b0;
      end else if (enable) begin
         ov_valid_ff <= heron_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         ov_sat_ff <= deg_out || (117'(abc_out) >= {heron_root[0], 48'b0});
         ov_deg_ff <= deg_out;
         ov_rem_ff <= DivWidth'(abc_out[AbcWidth-1:RW]);
         ov_low_ff <= abc_out[RW-1:0];
         ov_div_ff <= heron_root[0];
      end
   end

   // Restoring divider, one quotient bit per stage.
   logic [RW-1:0]       dv_valid_ff;
   logic [RW-1:0]       dv_sat_ff;
   logic [RW-1:0]       dv_deg_ff;
   logic [DivWidth-1:0] dv_rem_ff  [RW];
   logic [RW-1:0]       dv_low_ff  [RW];
   logic [DivWidth-1:0] dv_div_ff  [RW];
   logic [RW-1:0]       dv_quot_ff [RW];

   for (genvar k = 0; k < RW; k++) begin : g_div
      logic                src_valid;
      logic                src_sat;
      logic                src_deg;
      logic [DivWidth-1:0] src_rem;
      logic [RW-1:0]       src_low;
      logic [DivWidth-1:0] src_div;
      logic [RW-1:0]       src_quot;
      logic [DivWidth:0]   shifted;
      logic [DivWidth-1:0] rem_in;
      logic [RW-1:0]       quot_in;

      if (k == 0) begin : g_first
         assign src_valid = ov_valid_ff;
         assign src_sat   = ov_sat_ff;
         assign src_deg   = ov_deg_ff;
         assign src_rem   = ov_rem_ff;
         assign src_low   = ov_low_ff;
         assign src_div   = ov_div_ff;
         assign src_quot  = '0;
      end else begin : g_next
         assign src_valid = dv_valid_ff[k-1];
         assign src_sat   = dv_sat_ff[k-1];
         assign src_deg   = dv_deg_ff[k-1];
         assign src_rem   = dv_rem_ff[k-1];
         assign src_low   = dv_low_ff[k-1];
         assign src_div   = dv_div_ff[k-1];
         assign src_quot  = dv_quot_ff[k-1];
      end

      always_comb begin
         shifted = {src_rem, src_low[RW-1]};
         if (shifted >= {1'b0, src_div}) begin
            rem_in  = DivWidth'(shifted - {1'b0, src_div});
            quot_in = {src_quot[RW-2:0], 1'b1};
         end else begin
            rem_in  = shifted[DivWidth-1:0];
            quot_in = {src_quot[RW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[k] <= 1'b0;
         end else if (enable) begin
            dv_valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            dv_sat_ff[k]  <= src_sat;
            dv_deg_ff[k]  <= src_deg;
            dv_rem_ff[k]  <= rem_in;
            dv_low_ff[k]  <= {src_low[RW-2:0], 1'b0};
            dv_div_ff[k]  <= src_div;
            dv_quot_ff[k] <= quot_in;
         end
      end
   end

   // Output register.
   logic             rsp_valid_ff;
   tcr_pkg::rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= dv_valid_ff[RW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_data_ff.circle_radius <= dv_sat_ff[RW-1] ? tcr_pkg::RADIUS_MAX
                                                      : dv_quot_ff[RW-1];
         rsp_data_ff.degenerate    <= dv_deg_ff[RW-1];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.degenerate |->
         rsp_data_ff.circle_radius == tcr_pkg::RADIUS_MAX)
      else $error("degenerate result without saturated radius");

   assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(!enable))
      else $error("input buffer loaded while the pipeline advanced");

   assert property (@(posedge clock) disable iff (reset)
      entry_valid && !enable |=> skid_valid_ff)
      else $error("transaction dropped during a stall");

endmodule
